>>> design/iwo_pkg.sv
// ----------------------------------------------------------------------------
// iwo_pkg: shared types and constants of the wavetable oscillator
// Table geometry, phase format, queue entry and configuration bundle.
// ----------------------------------------------------------------------------
package iwo_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH + 1);
  localparam int FRAC_BITS   = 20;
  localparam int INCR_W      = 32;
  localparam int WORD_W      = 16;
  localparam int CNT_W       = 32;
  localparam int PROD_W      = WORD_W + 1 + FRAC_BITS + 1;
  localparam int SCALED_W    = 2 * WORD_W;
  localparam int KCNT_W      = $clog2(IDX_W);
  localparam int TDATA_IN_W  = 32;
  localparam int TDATA_OUT_W = 16;
  localparam int FUNC_W      = 2;

  // Register addresses (word index on the configuration port)
  localparam logic [1:0] REG_PHASE_INCR   = 2'd0;
  localparam logic [1:0] REG_AMPLITUDE    = 2'd1;
  localparam logic [1:0] REG_TABLE_LEN    = 2'd2;
  localparam logic [1:0] REG_SAMPLE_COUNT = 2'd3;

  typedef enum logic [FUNC_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef struct packed {
    op_e                       op;
    logic [IDX_W-1:0]          index;
    logic signed [WORD_W-1:0]  value;
  } qent_t;

  typedef struct packed {
    logic [INCR_W-1:0]         phase_incr;
    logic signed [WORD_W-1:0]  amplitude;
    logic [IDX_W-1:0]          table_len;
    logic [CNT_W-1:0]          sample_count;
  } cfg_t;

endpackage

>>> design/iwo_front.sv
// ----------------------------------------------------------------------------
// iwo_front: input stage of the wavetable oscillator
// Accepts stream items, drops meaningless ones and queues the rest.
// ----------------------------------------------------------------------------
module iwo_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [iwo_pkg::TDATA_IN_W-1:0] s_axis_tdata,
  input  logic [iwo_pkg::FUNC_W-1:0]   s_axis_tuser,
  output logic                         q_valid_o,
  output iwo_pkg::qent_t               q_entry_o,
  input  logic                         q_pop_i
);
  import iwo_pkg::*;

  qent_t       fifo_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;
  logic        accept, keep, push;
  qent_t       entry;

  assign s_axis_tready = (count_q != 2'd2);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    entry.op    = op_e'(s_axis_tuser);
    entry.index = s_axis_tdata[IDX_W-1:0];
    entry.value = s_axis_tdata[IDX_W+WORD_W-1:IDX_W];
    case (s_axis_tuser)
      OP_WRITE:   keep = (entry.index <= IDX_W'(TABLE_DEPTH));
      OP_TICK:    keep = 1'b1;
      OP_RESTART: keep = 1'b1;
      default:    keep = 1'b0;
    endcase
  end

  assign push      = accept && keep;
  assign q_valid_o = (count_q != 2'd0);
  assign q_entry_o = fifo_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !(q_pop_i && q_valid_o)) begin
      count_d = count_q + 2'd1;
    end else if (!push && q_pop_i && q_valid_o) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i && q_valid_o) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

endmodule

>>> design/iwo_back.sv
// ----------------------------------------------------------------------------
// iwo_back: execution stage of the wavetable oscillator
// Holds the table and phase, interpolates, scales and drives the result.
// ----------------------------------------------------------------------------
module iwo_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  iwo_pkg::cfg_t                 cfg_i,
  input  logic                          q_valid_i,
  input  iwo_pkg::qent_t                q_entry_i,
  output logic                          q_pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [iwo_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);
  import iwo_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RED  = 6'b000010,
    S_RD   = 6'b000100,
    S_MUL1 = 6'b001000,
    S_MUL2 = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  localparam logic signed [PROD_W-1:0]   INTERP_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SCALED_W-1:0] SCALE_HALF  = SCALED_W'(1) << (WORD_W - 2);
  localparam logic signed [SCALED_W-1:0] SAT_MAX     = SCALED_W'(32767);
  localparam logic signed [SCALED_W-1:0] SAT_MIN     = -SCALED_W'(32768);

  state_e                     state_q, state_d;
  logic [IDX_W-1:0]           phase_int_q, phase_int_d;
  logic [FRAC_BITS-1:0]       phase_frac_q, phase_frac_d;
  logic [CNT_W-1:0]           done_q, done_d;
  logic [KCNT_W-1:0]          k_q, k_d;
  logic                       red_post_q, red_post_d;
  logic                       out_valid_q, out_valid_d;
  logic [WORD_W-1:0]          out_data_q;
  logic                       out_last_q;
  logic                       load_out, mem_we;

  logic signed [WORD_W-1:0]   mem [TABLE_DEPTH+1];
  logic signed [WORD_W-1:0]   rd1_q, rd2_q;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [SCALED_W-1:0] scaled_q, scaled_d;

  logic [IDX_W-1:0]           len;
  logic [2*IDX_W-1:0]         len_sh, r_ext;
  logic signed [WORD_W:0]     diff;
  logic signed [PROD_W-1:0]   interp_t;
  logic signed [WORD_W-1:0]   v16;
  logic signed [SCALED_W-1:0] rs;
  logic [WORD_W-1:0]          sat;
  logic [FRAC_BITS+IDX_W-1:0] adv_sum;
  logic [IDX_W-1:0]           adv_int, adv_sub;

  // Clamp the period to the table range
  always_comb begin
    if (cfg_i.table_len < IDX_W'(2)) begin
      len = IDX_W'(2);
    end else if (cfg_i.table_len > IDX_W'(TABLE_DEPTH)) begin
      len = IDX_W'(TABLE_DEPTH);
    end else begin
      len = cfg_i.table_len;
    end
  end

  assign len_sh = {{IDX_W{1'b0}}, len} << k_q;
  assign r_ext  = {{IDX_W{1'b0}}, phase_int_q};

  assign diff     = {rd2_q[WORD_W-1], rd2_q} - {rd1_q[WORD_W-1], rd1_q};
  assign prod_d   = diff * $signed({1'b0, phase_frac_q});
  assign interp_t = (prod_q + INTERP_HALF) >>> FRAC_BITS;
  assign v16      = rd1_q + interp_t[WORD_W-1:0];
  assign scaled_d = v16 * cfg_i.amplitude;
  assign rs       = (scaled_q + SCALE_HALF) >>> (WORD_W - 1);

  always_comb begin
    if (rs > SAT_MAX) begin
      sat = 16'h7fff;
    end else if (rs < SAT_MIN) begin
      sat = 16'h8000;
    end else begin
      sat = rs[WORD_W-1:0];
    end
  end

  assign adv_sum = {phase_int_q, phase_frac_q}
                 + (FRAC_BITS+IDX_W)'(cfg_i.phase_incr);
  assign adv_int = adv_sum[FRAC_BITS+IDX_W-1:FRAC_BITS];
  assign adv_sub = adv_int - len;

  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;
  assign load_out = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d      = state_q;
    phase_int_d  = phase_int_q;
    phase_frac_d = phase_frac_q;
    done_d       = done_q;
    k_d          = k_q;
    red_post_d   = red_post_q;
    mem_we       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          case (q_entry_i.op)
            OP_WRITE: mem_we = 1'b1;
            OP_RESTART: begin
              phase_int_d  = '0;
              phase_frac_d = '0;
              done_d       = '0;
            end
            OP_TICK: begin
              if (done_q < cfg_i.sample_count) begin
                if (phase_int_q < len) begin
                  state_d = S_RD;
                end else begin
                  state_d    = S_RED;
                  red_post_d = 1'b0;
                  k_d        = KCNT_W'(IDX_W - 1);
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RED: begin
        // Restoring remainder of the integer phase by the period
        if (phase_int_q < len) begin
          state_d = red_post_q ? S_IDLE : S_RD;
        end else begin
          if (r_ext >= len_sh) begin
            phase_int_d = phase_int_q - len_sh[IDX_W-1:0];
          end
          k_d = k_q - KCNT_W'(1);
        end
      end
      S_RD:   state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_OUT;
      S_OUT: begin
        if (load_out) begin
          done_d       = done_q + CNT_W'(1);
          phase_frac_d = adv_sum[FRAC_BITS-1:0];
          if (adv_int < len) begin
            phase_int_d = adv_int;
            state_d     = S_IDLE;
          end else if (adv_sub < len) begin
            phase_int_d = adv_sub;
            state_d     = S_IDLE;
          end else begin
            phase_int_d = adv_int;
            state_d     = S_RED;
            red_post_d  = 1'b1;
            k_d         = KCNT_W'(IDX_W - 1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !m_axis_tready) || load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_int_q  <= '0;
      phase_frac_q <= '0;
      done_q       <= '0;
      k_q          <= '0;
      red_post_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_int_q  <= phase_int_d;
      phase_frac_q <= phase_frac_d;
      done_q       <= done_d;
      k_q          <= k_d;
      red_post_q   <= red_post_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Table: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[q_entry_i.index] <= q_entry_i.value;
    end
    if (state_q == S_RD) begin
      rd1_q <= mem[phase_int_q];
      rd2_q <= mem[phase_int_q + IDX_W'(1)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL1) begin
      prod_q <= prod_d;
    end
    if (state_q == S_MUL2) begin
      scaled_q <= scaled_d;
    end
    if (load_out) begin
      out_data_q <= sat;
      out_last_q <= ((done_q + CNT_W'(1)) == cfg_i.sample_count);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> design/interpolating_wavetable_oscillator.sv
// ----------------------------------------------------------------------------
// interpolating_wavetable_oscillator: linear-interpolating wavetable source
// Streams one Q1.15 sample per tick item from a host-loaded table.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the function (write table word, tick, restart),
// tdata carries the table index and word. Output stream: tdata carries the
// saturated sample, tlast marks the final sample of a run.
// The APB port sets phase step, gain, period length and run length; write
// it only while no item is in flight.
// Items pass a two-entry queue. Table writes and restarts are done in the
// execution stage's idle state. A producing tick passes from the queue to
// the output register through its steps (read two neighbor entries,
// interpolate, scale, round and saturate). When the advanced phase wraps
// more than one period, a restoring remainder unit reduces it; the same
// unit reduces a phase left beyond a shortened period before use.
// Ticks past the end of a run give no item.
// Reset clears phase, sample counter and registers to their defaults; the
// table holds garbage until written. When the receiver stalls, the finished
// sample holds in the output register and the execution stage waits, while
// the queue keeps taking items until full.
module interpolating_wavetable_oscillator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [12:0] table_index, [28:13] table_value, [31:29] zero
  input  logic [iwo_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
  // [1:0] func
  input  logic [iwo_pkg::FUNC_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] sample
  output logic [iwo_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [3:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import iwo_pkg::*;

  cfg_t        cfg_q;
  logic        cfg_we;
  logic        q_valid, q_pop;
  qent_t       q_entry;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_incr   <= '0;
      cfg_q.amplitude    <= 16'sh7fff;
      cfg_q.table_len    <= IDX_W'(TABLE_DEPTH);
      cfg_q.sample_count <= '0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_PHASE_INCR:   cfg_q.phase_incr   <= pwdata;
        REG_AMPLITUDE:    cfg_q.amplitude    <= pwdata[WORD_W-1:0];
        REG_TABLE_LEN:    cfg_q.table_len    <= pwdata[IDX_W-1:0];
        REG_SAMPLE_COUNT: cfg_q.sample_count <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PHASE_INCR:   prdata = cfg_q.phase_incr;
      REG_AMPLITUDE:    prdata = {16'h0000, cfg_q.amplitude};
      REG_TABLE_LEN:    prdata = {19'h0, cfg_q.table_len};
      REG_SAMPLE_COUNT: prdata = cfg_q.sample_count;
      default:          prdata = '0;
    endcase
  end

  iwo_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid_o     (q_valid),
    .q_entry_o     (q_entry),
    .q_pop_i       (q_pop)
  );

  iwo_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
